@@ rtl/core/windowed_neighbor_coincidence_detect_unit_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the neighbour coincidence detector
// Shorthand for clocked implication and invariant checks with reset masking.
// ----------------------------------------------------------------------------
`ifndef WINDOWED_NEIGHBOR_COINCIDENCE_DETECT_UNIT_MACROS_SVH
`define WINDOWED_NEIGHBOR_COINCIDENCE_DETECT_UNIT_MACROS_SVH

// same-cycle implication
`define WNCD_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define WNCD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

// invariant
`define WNCD_ASSERT_ALWAYS(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (cond)) \
        else $error(msg);

`endif

@@ rtl/core/wncd_pkg.sv @@
// ----------------------------------------------------------------------------
// wncd_pkg
// Shared widths, register indexes and controller/datapath interface types.
// ----------------------------------------------------------------------------
package wncd_pkg;

    localparam int RD_W       = 6;
    localparam int ROUND_W    = 32;
    localparam int MASK_W     = 4;
    localparam int HITS_W     = 3;
    localparam int IN_LANES   = 4;
    localparam int NC_W       = 3;
    localparam int WL_W       = 5;
    localparam int VR_W       = 6;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 6;

    localparam logic [CFG_IDX_W-1:0] CFG_NEIGHBOR_COUNT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_LEN     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_VALUE_RANGE    = 2'd2;

    localparam logic [NC_W-1:0] NC_RESET = 3'd4;
    localparam logic [WL_W-1:0] WL_RESET = 5'd4;
    localparam logic [VR_W-1:0] VR_RESET = 6'd10;

    localparam logic [HITS_W-1:0] MIN_HITS = 3'd3;
    localparam logic [NC_W-1:0]   MIN_ACT  = 3'd2;

    // controller -> datapath
    typedef struct packed {
        logic accept;
        logic clr;
        logic ev_rd;
        logic ev_wr;
        logic in_rd;
        logic in_wr;
        logic pre;
        logic scan;
        logic flush;
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic cfg_clr;
        logic clr_last;
        logic act_ok;
        logic range_zero;
        logic scan_adv;
        logic scan_last;
        logic flush_ok;
    } t_stat;

endpackage

@@ rtl/core/windowed_neighbor_coincidence_detect_unit.sv @@
// ----------------------------------------------------------------------------
// windowed_neighbor_coincidence_detect_unit
// Sliding-window coincidence detector over up to four neighbour readings.
// ----------------------------------------------------------------------------
// One round is taken at a time. With more than two active neighbours a round
// runs through the sequencer states in order, R being value_range capped at
// VALUE_MAX, and the scan and hand-over wait while the output side stalls:
// read-modify-write on the per-neighbour count memories (evict the oldest
// reading, add the new one), a step to prime the scan, then the ascending
// scan over values 1 to R and a final step to hand over the last event; with
// R zero the round ends after priming. With two or fewer active neighbours a
// round is accepted without leaving idle and gives no results. After reset,
// and after every write of neighbor_count or window_len, a clearing pass over
// max(VALUE_MAX + 1, WINDOW_MAX) entries (33 by default) empties the window
// and counts; no round is taken meanwhile. Configuration writes are always
// accepted.
`include "windowed_neighbor_coincidence_detect_unit_macros.svh"

module windowed_neighbor_coincidence_detect_unit #(
    parameter int WINDOW_MAX = 16,
    parameter int VALUE_MAX  = 32,
    parameter int NEIGHBORS  = 4
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [wncd_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [wncd_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic [wncd_pkg::RD_W-1:0]         i_reading_0,
    input  logic [wncd_pkg::RD_W-1:0]         i_reading_1,
    input  logic [wncd_pkg::RD_W-1:0]         i_reading_2,
    input  logic [wncd_pkg::RD_W-1:0]         i_reading_3,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic [wncd_pkg::ROUND_W-1:0]      o_round_index,
    output logic [wncd_pkg::RD_W-1:0]         o_event_value,
    output logic [wncd_pkg::MASK_W-1:0]       o_trigger_mask,
    output logic [wncd_pkg::HITS_W-1:0]       o_hit_count,
    output logic                              o_last_event
);
    import wncd_pkg::*;

    t_cmd  cmd;
    t_stat stat;
    logic  cfg_we;
    logic  res_ok;
    logic  win_clr_wr;

    assign o_cfg_ready = 1'b1;
    assign cfg_we      = i_cfg_valid && o_cfg_ready;

    wncd_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    wncd_dpath #(
        .WINDOW_MAX (WINDOW_MAX),
        .VALUE_MAX  (VALUE_MAX),
        .NEIGHBORS  (NEIGHBORS)
    ) u_dpath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_stat         (stat),
        .i_cfg_we       (cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_reading_0    (i_reading_0),
        .i_reading_1    (i_reading_1),
        .i_reading_2    (i_reading_2),
        .i_reading_3    (i_reading_3),
        .i_out_stall    (i_out_stall),
        .o_out_valid    (o_out_valid),
        .o_round_index  (o_round_index),
        .o_event_value  (o_event_value),
        .o_trigger_mask (o_trigger_mask),
        .o_hit_count    (o_hit_count),
        .o_last_event   (o_last_event)
    );

    assign res_ok     = (o_hit_count >= MIN_HITS)
                     && (o_hit_count == HITS_W'($countones(o_trigger_mask)));
    assign win_clr_wr = cfg_we
                     && ((i_cfg_index == CFG_NEIGHBOR_COUNT) || (i_cfg_index == CFG_WINDOW_LEN));

    // a presented result is a real coincidence and its count matches its mask
    `WNCD_ASSERT_IMPLY(a_hit_mask, i_clk, i_rst_n, o_out_valid, res_ok, "bad hit count")

    // a window reset must hold off rounds for the clearing pass
    `WNCD_ASSERT_NEXT(a_cfg_clear, i_clk, i_rst_n, win_clr_wr, o_in_stall, "round in clear")

    // the sequencer issues at most one phase command per cycle
    `WNCD_ASSERT_ALWAYS(a_cmd_onehot, i_clk, i_rst_n, $onehot0(cmd), "overlapping commands")

endmodule

@@ rtl/core/wncd_ctrl.sv @@
// ----------------------------------------------------------------------------
// wncd_ctrl
// Round sequencer: clearing pass, window/count update phases, value scan.
// ----------------------------------------------------------------------------
module wncd_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    input  wncd_pkg::t_stat  i_stat,
    output wncd_pkg::t_cmd   o_cmd
);
    import wncd_pkg::*;

    typedef enum logic [8:0] {
        S_CLEAR = 9'b000000001,
        S_IDLE  = 9'b000000010,
        S_EVRD  = 9'b000000100,
        S_EVWR  = 9'b000001000,
        S_INRD  = 9'b000010000,
        S_INWR  = 9'b000100000,
        S_PRE   = 9'b001000000,
        S_SCAN  = 9'b010000000,
        S_FLUSH = 9'b100000000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_CLEAR: begin
                o_cmd.clr = 1'b1;
                if (i_stat.clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                o_cmd.accept = i_in_valid;
                if (i_in_valid && i_stat.act_ok) begin
                    n_state = S_EVRD;
                end
            end
            S_EVRD: begin
                o_cmd.ev_rd = 1'b1;
                n_state     = S_EVWR;
            end
            S_EVWR: begin
                o_cmd.ev_wr = 1'b1;
                n_state     = S_INRD;
            end
            S_INRD: begin
                o_cmd.in_rd = 1'b1;
                n_state     = S_INWR;
            end
            S_INWR: begin
                o_cmd.in_wr = 1'b1;
                n_state     = S_PRE;
            end
            S_PRE: begin
                o_cmd.pre = 1'b1;
                n_state   = i_stat.range_zero ? S_IDLE : S_SCAN;
            end
            S_SCAN: begin
                o_cmd.scan = 1'b1;
                if (i_stat.scan_adv && i_stat.scan_last) begin
                    n_state = S_FLUSH;
                end
            end
            S_FLUSH: begin
                o_cmd.flush = 1'b1;
                if (i_stat.flush_ok) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
        // window/count reset restarts the clearing pass from any state
        if (i_stat.cfg_clr) begin
            n_state = S_CLEAR;
        end
    end

    assign o_in_stall = (r_state != S_IDLE);

endmodule

@@ rtl/core/wncd_dpath.sv @@
// ----------------------------------------------------------------------------
// wncd_dpath
// Config registers, window store, per-neighbour value counts, scan and
// output registers.
// ----------------------------------------------------------------------------
module wncd_dpath #(
    parameter int WINDOW_MAX = 16,
    parameter int VALUE_MAX  = 32,
    parameter int NEIGHBORS  = 4
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  wncd_pkg::t_cmd                     i_cmd,
    output wncd_pkg::t_stat                    o_stat,
    input  logic                               i_cfg_we,
    input  logic [wncd_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [wncd_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    input  logic [wncd_pkg::RD_W-1:0]          i_reading_0,
    input  logic [wncd_pkg::RD_W-1:0]          i_reading_1,
    input  logic [wncd_pkg::RD_W-1:0]          i_reading_2,
    input  logic [wncd_pkg::RD_W-1:0]          i_reading_3,
    input  logic                               i_out_stall,
    output logic                               o_out_valid,
    output logic [wncd_pkg::ROUND_W-1:0]       o_round_index,
    output logic [wncd_pkg::RD_W-1:0]          o_event_value,
    output logic [wncd_pkg::MASK_W-1:0]        o_trigger_mask,
    output logic [wncd_pkg::HITS_W-1:0]        o_hit_count,
    output logic                               o_last_event
);
    import wncd_pkg::*;

    localparam int LANES = (NEIGHBORS < IN_LANES) ? NEIGHBORS : IN_LANES;
    localparam int SW    = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
    localparam int CMPW  = (SW + 1 > WL_W) ? SW + 1 : WL_W;
    localparam int CIW   = $clog2(VALUE_MAX + 1);
    localparam int CW    = $clog2(WINDOW_MAX + 1);
    localparam int CLRN  = (VALUE_MAX + 1 > WINDOW_MAX) ? VALUE_MAX + 1 : WINDOW_MAX;
    localparam int KW    = $clog2(CLRN);
    localparam int RMAX  = (VALUE_MAX < 63) ? VALUE_MAX : 63;
    localparam int LMAX  = (WINDOW_MAX < 31) ? WINDOW_MAX : 31;

    typedef logic [LANES-1:0][RD_W-1:0] t_row;

    // configuration
    logic [NC_W-1:0] r_nc;
    logic [WL_W-1:0] r_wl;
    logic [VR_W-1:0] r_vr;
    logic            cfg_clr;

    logic [WL_W-1:0]  eff_len;
    logic [VR_W-1:0]  eff_range;
    logic [NC_W-1:0]  act;
    logic [LANES-1:0] lane_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_nc <= NC_RESET;
            r_wl <= WL_RESET;
            r_vr <= VR_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_NEIGHBOR_COUNT: r_nc <= i_cfg_data[NC_W-1:0];
                CFG_WINDOW_LEN:     r_wl <= i_cfg_data[WL_W-1:0];
                CFG_VALUE_RANGE:    r_vr <= i_cfg_data[VR_W-1:0];
                default: ;
            endcase
        end
    end

    assign cfg_clr = i_cfg_we &&
        ((i_cfg_index == CFG_NEIGHBOR_COUNT) || (i_cfg_index == CFG_WINDOW_LEN));

    always_comb begin
        if (r_wl == '0) begin
            eff_len = WL_W'(1);
        end else if (r_wl > WL_W'(LMAX)) begin
            eff_len = WL_W'(LMAX);
        end else begin
            eff_len = r_wl;
        end
        eff_range = (r_vr > VR_W'(RMAX)) ? VR_W'(RMAX) : r_vr;
        act       = (r_nc > NC_W'(LANES)) ? NC_W'(LANES) : r_nc;
    end

    // slot and round bookkeeping
    logic [SW-1:0]      r_slot;
    logic [SW-1:0]      slot_eff;
    logic [SW-1:0]      nxt_slot;
    logic [CMPW-1:0]    slot_inc;
    logic [SW-1:0]      r_cur_slot;
    logic [ROUND_W-1:0] r_round;
    logic [ROUND_W-1:0] r_cur_round;

    always_comb begin
        slot_eff = (CMPW'(r_slot) < CMPW'(eff_len)) ? r_slot : '0;
        slot_inc = CMPW'(slot_eff) + CMPW'(1);
        nxt_slot = (slot_inc >= CMPW'(eff_len)) ? '0 : SW'(slot_inc);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot  <= '0;
            r_round <= '0;
        end else begin
            if (cfg_clr) begin
                r_slot <= '0;
            end else if (i_cmd.accept) begin
                r_slot <= nxt_slot;
            end
            if (i_cmd.accept) begin
                r_round <= r_round + ROUND_W'(1);
            end
        end
    end

    logic [RD_W-1:0] rd_in [IN_LANES];
    logic [RD_W-1:0] r_rd  [LANES];

    assign rd_in[0] = i_reading_0;
    assign rd_in[1] = i_reading_1;
    assign rd_in[2] = i_reading_2;
    assign rd_in[3] = i_reading_3;

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_cur_round <= r_round;
            r_cur_slot  <= slot_eff;
            for (int k = 0; k < LANES; k++) begin
                r_rd[k] <= rd_in[k];
            end
        end
    end

    // clearing pass over both stores
    logic [KW-1:0] r_clr_idx;
    logic          clr_cnt_ok;
    logic          clr_win_ok;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_idx <= '0;
        end else if (cfg_clr) begin
            r_clr_idx <= '0;
        end else if (i_cmd.clr && (r_clr_idx != KW'(CLRN - 1))) begin
            r_clr_idx <= r_clr_idx + KW'(1);
        end
    end

    assign clr_cnt_ok = (r_clr_idx <= KW'(VALUE_MAX));
    assign clr_win_ok = (r_clr_idx <= KW'(WINDOW_MAX - 1));

    // window store: one row per slot, a zero entry is empty
    t_row            r_win_mem [WINDOW_MAX];
    t_row            r_wrow;
    t_row            win_row_new;
    t_row            win_wdata;
    logic [SW-1:0]   win_addr;
    logic            win_we;
    logic [LANES-1:0] old_valid;
    logic [LANES-1:0] new_valid;

    always_comb begin
        for (int k = 0; k < LANES; k++) begin
            lane_en[k]     = (NC_W'(k) < act);
            old_valid[k]   = (r_wrow[k] != '0);
            new_valid[k]   = (r_rd[k] != '0) && (r_rd[k] <= eff_range);
            win_row_new[k] = lane_en[k] ? (new_valid[k] ? r_rd[k] : '0) : r_wrow[k];
        end
        win_we    = (i_cmd.clr && clr_win_ok) || i_cmd.ev_rd;
        win_addr  = i_cmd.clr ? SW'(r_clr_idx) : r_cur_slot;
        win_wdata = i_cmd.clr ? '0 : win_row_new;
    end

    always_ff @(posedge i_clk) begin
        if (win_we) begin
            r_win_mem[win_addr] <= win_wdata;
        end
        if (i_cmd.accept) begin
            r_wrow <= r_win_mem[slot_eff];
        end
    end

    // scan position: value whose counts sit in the read registers
    logic [RD_W-1:0]  r_v;
    logic [RD_W-1:0]  n_v;
    logic [CW-1:0]    r_cnt_rd [LANES];
    logic [LANES-1:0] present;

    // per-neighbour count memories
    for (genvar k = 0; k < LANES; k++) begin : g_lane
        logic [CW-1:0]  r_mem [VALUE_MAX+1];
        logic [CIW-1:0] raddr;
        logic [CIW-1:0] waddr;
        logic [CW-1:0]  wdata;
        logic           we;

        always_comb begin
            if (i_cmd.ev_rd) begin
                raddr = CIW'(r_wrow[k]);
            end else if (i_cmd.in_rd) begin
                raddr = CIW'(r_rd[k]);
            end else begin
                raddr = CIW'(n_v);
            end
            if (i_cmd.clr) begin
                waddr = CIW'(r_clr_idx);
                wdata = '0;
            end else if (i_cmd.ev_wr) begin
                waddr = CIW'(r_wrow[k]);
                wdata = r_cnt_rd[k] - CW'(1);
            end else begin
                waddr = CIW'(r_rd[k]);
                wdata = r_cnt_rd[k] + CW'(1);
            end
            we = (i_cmd.clr && clr_cnt_ok)
               || (i_cmd.ev_wr && lane_en[k] && old_valid[k] && (r_cnt_rd[k] != '0))
               || (i_cmd.in_wr && lane_en[k] && new_valid[k]);
        end

        always_ff @(posedge i_clk) begin
            if (we) begin
                r_mem[waddr] <= wdata;
            end
            r_cnt_rd[k] <= r_mem[raddr];
        end

        assign present[k] = lane_en[k] && (r_cnt_rd[k] != '0);
    end

    // scan, one-deep pending result and output register
    logic [HITS_W-1:0] hits;
    logic              hit;
    logic              out_free;
    logic              blocked;
    logic              scan_last;
    logic              load_pend;
    logic              load_out;

    logic              r_pend_v;
    logic [RD_W-1:0]   r_pend_value;
    logic [MASK_W-1:0] r_pend_mask;
    logic [HITS_W-1:0] r_pend_hits;
    logic              r_o_valid;

    always_comb begin
        hits      = HITS_W'($countones(present));
        hit       = (hits >= MIN_HITS);
        out_free  = !r_o_valid || !i_out_stall;
        blocked   = hit && r_pend_v && !out_free;
        scan_last = (r_v == eff_range);
        load_pend = i_cmd.scan && hit && !blocked;
        load_out  = r_pend_v && out_free && ((i_cmd.scan && hit) || i_cmd.flush);
        if (i_cmd.pre) begin
            n_v = RD_W'(1);
        end else if (i_cmd.scan && !blocked && !scan_last) begin
            n_v = r_v + RD_W'(1);
        end else begin
            n_v = r_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_v <= n_v;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend_v  <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            if (load_pend) begin
                r_pend_v <= 1'b1;
            end else if (i_cmd.flush && out_free) begin
                r_pend_v <= 1'b0;
            end
            if (load_out) begin
                r_o_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_pend) begin
            r_pend_value <= r_v;
            r_pend_mask  <= MASK_W'(present);
            r_pend_hits  <= hits;
        end
        if (load_out) begin
            o_round_index  <= r_cur_round;
            o_event_value  <= r_pend_value;
            o_trigger_mask <= r_pend_mask;
            o_hit_count    <= r_pend_hits;
            o_last_event   <= i_cmd.flush;
        end
    end

    assign o_out_valid = r_o_valid;

    always_comb begin
        o_stat            = '0;
        o_stat.cfg_clr    = cfg_clr;
        o_stat.clr_last   = (r_clr_idx == KW'(CLRN - 1));
        o_stat.act_ok     = (act > MIN_ACT);
        o_stat.range_zero = (eff_range == '0);
        o_stat.scan_adv   = !blocked;
        o_stat.scan_last  = scan_last;
        o_stat.flush_ok   = !r_pend_v || out_free;
    end

endmodule
